// ----- hdl/bmhq_pkg.sv -----
// Package for the binary min-heap queue: sizes, codes and the controller command types.
// Used by the controller, the datapath and the top level; it depends on nothing.
package bmhq_pkg;

  localparam int CAPACITY_DEF      = 64;
  localparam int PRIORITY_BITS_DEF = 16;
  localparam int TAG_BITS_DEF      = 16;

  typedef enum logic [1:0] {
    ERR_OK         = 2'd0,
    ERR_EMPTY      = 2'd1,
    ERR_FULL       = 2'd2,
    ERR_UNUSED     = 2'd3
  } err_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_MOVE_RD,
    ST_DN_MOVE_WR,
    ST_DN_RD,
    ST_DN_CMP,
    ST_ROOT_RD,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic ins_write;   // write the new entry at the last slot, pos <= count
    logic up_read;     // read the entry at pos and its parent
    logic dn_move_rd;  // read the last entry
    logic dn_move_wr;  // write it to the root, pos <= 0
    logic dn_read;     // read both children of pos
    logic swap;        // swap pos and the chosen slot, pos <= chosen slot
    logic root_read;   // read the root for the result
    logic cnt_inc;
    logic cnt_dec;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic pos_zero;    // sift-up has reached the root
    logic up_less;     // entry at pos is strictly smaller than its parent
    logic dn_has_child;
    logic dn_less;     // chosen child is strictly smaller than the entry
  } stat_t;

endpackage

// ----- hdl/binary_min_heap_queue_core.sv -----
// Binary min-heap priority queue: one insert or remove per command, one result each.
// Latency depends on the error check and on how many levels an insert climbs or a remove
// descends. Busy covers the strobe cycle, so the next command is taken in the cycle after
// the result. The sift loop against the two-port heap memory sets the latency.
// Reset (rst_n low, synchronous) empties the queue; the result strobe cannot be stalled.
module binary_min_heap_queue_core #(
  parameter int CAPACITY      = bmhq_pkg::CAPACITY_DEF,
  parameter int PRIORITY_BITS = bmhq_pkg::PRIORITY_BITS_DEF,
  parameter int TAG_BITS      = bmhq_pkg::TAG_BITS_DEF,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_kind,
  input  logic signed [PRIORITY_BITS-1:0] in_priority_req,
  input  logic        [TAG_BITS-1:0]      in_payload_tag,
  output logic                            out_valid,
  output logic signed [PRIORITY_BITS-1:0] out_top_priority,
  output logic        [TAG_BITS-1:0]      out_top_tag,
  output logic        [CW-1:0]            out_entry_count,
  output logic                            out_is_empty,
  output logic        [1:0]               out_error_code
);

  bmhq_pkg::cmd_t  cmd;
  bmhq_pkg::stat_t stat;
  bmhq_pkg::err_t  err;
  logic signed [PRIORITY_BITS-1:0] root_prio;
  logic        [TAG_BITS-1:0]      root_tag;
  logic        [CW-1:0]            count;
  logic                            done;

  bmhq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .kind  (in_kind),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done),
    .err   (err)
  );

  bmhq_dp #(
    .CAPACITY      (CAPACITY),
    .PRIORITY_BITS (PRIORITY_BITS),
    .TAG_BITS      (TAG_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_prio   (in_priority_req),
    .in_tag    (in_payload_tag),
    .cmd       (cmd),
    .stat      (stat),
    .root_prio (root_prio),
    .root_tag  (root_tag),
    .count     (count)
  );

  assign out_valid        = done;
  assign out_is_empty     = (count == '0);
  assign out_top_priority = out_is_empty ? '0 : root_prio;
  assign out_top_tag      = out_is_empty ? '0 : root_tag;
  assign out_entry_count  = count;
  assign out_error_code   = err;

endmodule

// ----- hdl/bmhq_ctrl.sv -----
// Controller for the binary min-heap queue: sequences insert and remove sifts.
// Depends on bmhq_pkg for the state, command and status types.
module bmhq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             kind,
  input  bmhq_pkg::stat_t  stat,
  output bmhq_pkg::cmd_t   cmd,
  output logic             busy,
  output logic             done,
  output bmhq_pkg::err_t   err
);

  bmhq_pkg::state_t state_r, state_nxt;
  bmhq_pkg::err_t   err_r, err_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bmhq_pkg::ST_IDLE;
      err_r   <= bmhq_pkg::ERR_OK;
    end else begin
      state_r <= state_nxt;
      err_r   <= err_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    err_nxt   = err_r;
    cmd       = '0;
    done      = 1'b0;
    case (state_r)
      bmhq_pkg::ST_IDLE: begin
        if (start) begin
          err_nxt = bmhq_pkg::ERR_OK;
          if (!kind) begin
            if (stat.full) begin
              err_nxt   = bmhq_pkg::ERR_FULL;
              state_nxt = bmhq_pkg::ST_ROOT_RD;
            end else begin
              cmd.ins_write = 1'b1;
              cmd.cnt_inc   = 1'b1;
              state_nxt     = bmhq_pkg::ST_UP_RD;
            end
          end else begin
            if (stat.empty) begin
              err_nxt   = bmhq_pkg::ERR_EMPTY;
              state_nxt = bmhq_pkg::ST_ROOT_RD;
            end else begin
              cmd.dn_move_rd = 1'b1;
              state_nxt      = bmhq_pkg::ST_DN_MOVE_WR;
            end
          end
        end
      end
      bmhq_pkg::ST_UP_RD: begin
        if (stat.pos_zero) begin
          state_nxt = bmhq_pkg::ST_ROOT_RD;
        end else begin
          cmd.up_read = 1'b1;
          state_nxt   = bmhq_pkg::ST_UP_CMP;
        end
      end
      bmhq_pkg::ST_UP_CMP: begin
        if (stat.up_less) begin
          cmd.swap  = 1'b1;
          state_nxt = bmhq_pkg::ST_UP_RD;
        end else begin
          state_nxt = bmhq_pkg::ST_ROOT_RD;
        end
      end
      bmhq_pkg::ST_DN_MOVE_WR: begin
        cmd.dn_move_wr = 1'b1;
        cmd.cnt_dec    = 1'b1;
        state_nxt      = bmhq_pkg::ST_DN_RD;
      end
      bmhq_pkg::ST_DN_RD: begin
        if (!stat.dn_has_child) begin
          state_nxt = bmhq_pkg::ST_ROOT_RD;
        end else begin
          cmd.dn_read = 1'b1;
          state_nxt   = bmhq_pkg::ST_DN_CMP;
        end
      end
      bmhq_pkg::ST_DN_CMP: begin
        if (stat.dn_less) begin
          cmd.swap  = 1'b1;
          state_nxt = bmhq_pkg::ST_DN_RD;
        end else begin
          state_nxt = bmhq_pkg::ST_ROOT_RD;
        end
      end
      bmhq_pkg::ST_ROOT_RD: begin
        cmd.root_read = 1'b1;
        state_nxt     = bmhq_pkg::ST_DONE;
      end
      bmhq_pkg::ST_DONE: begin
        done      = 1'b1;
        state_nxt = bmhq_pkg::ST_IDLE;
      end
      default: state_nxt = bmhq_pkg::ST_IDLE;
    endcase
  end

  assign busy = (state_r != bmhq_pkg::ST_IDLE);
  assign err  = err_r;

endmodule

// ----- hdl/bmhq_dp.sv -----
// Datapath for the binary min-heap queue: heap memory, count, position and compares.
// Depends on bmhq_pkg for the command and status types.
module bmhq_dp #(
  parameter int CAPACITY      = bmhq_pkg::CAPACITY_DEF,
  parameter int PRIORITY_BITS = bmhq_pkg::PRIORITY_BITS_DEF,
  parameter int TAG_BITS      = bmhq_pkg::TAG_BITS_DEF,
  localparam int AW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1),
  localparam int EW = PRIORITY_BITS + TAG_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic signed [PRIORITY_BITS-1:0] in_prio,
  input  logic        [TAG_BITS-1:0]      in_tag,
  input  bmhq_pkg::cmd_t                  cmd,
  output bmhq_pkg::stat_t                 stat,
  output logic signed [PRIORITY_BITS-1:0] root_prio,
  output logic        [TAG_BITS-1:0]      root_tag,
  output logic        [CW-1:0]            count
);

  // Each entry holds {priority, tag}. Reads use two ports, writes two ports
  // only for a swap; registered read data throughout.
  logic [EW-1:0] mem [CAPACITY];

  logic [CW-1:0] count_r;
  logic [AW-1:0] pos_r, other_r;
  logic [EW-1:0] rd_a_r, rd_b_r, rd_c_r;
  logic          has_r_r;
  logic [EW-1:0] root_r;

  // Address arithmetic, one bit wider to catch children past the end.
  logic [AW:0]   left_w, right_w;
  logic [AW-1:0] parent_w;

  assign parent_w = AW'((pos_r - AW'(1)) >> 1);
  assign left_w   = {pos_r, 1'b1};
  assign right_w  = left_w + (AW+1)'(1);

  logic signed [PRIORITY_BITS-1:0] pa, pb, pc, pick_p;
  logic                            pick_right;
  assign pa = rd_a_r[EW-1 -: PRIORITY_BITS];
  assign pb = rd_b_r[EW-1 -: PRIORITY_BITS];
  assign pc = rd_c_r[EW-1 -: PRIORITY_BITS];
  assign pick_right = has_r_r && (pc < pb);
  assign pick_p     = pick_right ? pc : pb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.cnt_inc) begin
      count_r <= count_r + CW'(1);
    end else if (cmd.cnt_dec) begin
      count_r <= count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_write) begin
      mem[count_r[AW-1:0]] <= {in_prio, in_tag};
      pos_r                <= count_r[AW-1:0];
    end
    if (cmd.up_read) begin
      rd_a_r  <= mem[pos_r];
      rd_b_r  <= mem[parent_w];
      other_r <= parent_w;
    end
    if (cmd.dn_move_rd) begin
      rd_a_r <= mem[AW'(count_r - CW'(1))];
    end
    if (cmd.dn_move_wr) begin
      mem[0] <= rd_a_r;
      pos_r  <= '0;
    end
    // The entry being sifted down stays in rd_a_r, so only the children are read.
    if (cmd.dn_read) begin
      rd_b_r  <= mem[left_w[AW-1:0]];
      rd_c_r  <= mem[AW'(right_w)];
      has_r_r <= (CW'(right_w) < count_r) && (right_w < (AW+1)'(CAPACITY));
    end
    if (cmd.swap) begin
      // Sift-up compares with the parent; sift-down with the chosen child.
      if (other_r == parent_w && stat.up_less && !cmd.dn_read) begin
        mem[pos_r]   <= rd_b_r;
        mem[other_r] <= rd_a_r;
        pos_r        <= other_r;
      end else begin
        mem[pos_r] <= pick_right ? rd_c_r : rd_b_r;
        if (pick_right) begin
          mem[AW'(right_w)] <= rd_a_r;
          pos_r             <= AW'(right_w);
        end else begin
          mem[left_w[AW-1:0]] <= rd_a_r;
          pos_r               <= left_w[AW-1:0];
        end
      end
    end
    if (cmd.root_read) begin
      root_r <= mem[0];
    end
  end

  // Sift-down reads leave other_r stale, so the up test also needs a mode bit.
  logic up_mode_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_mode_r <= 1'b0;
    end else if (cmd.ins_write) begin
      up_mode_r <= 1'b1;
    end else if (cmd.dn_move_rd) begin
      up_mode_r <= 1'b0;
    end
  end

  assign stat.full         = (count_r >= CW'(CAPACITY));
  assign stat.empty        = (count_r == '0);
  assign stat.pos_zero     = (pos_r == '0);
  assign stat.up_less      = up_mode_r && (pa < pb);
  assign stat.dn_has_child = (CW'(left_w) < count_r) && (left_w < (AW+1)'(CAPACITY));
  assign stat.dn_less      = !up_mode_r && (pick_p < pa);

  assign root_prio = root_r[EW-1 -: PRIORITY_BITS];
  assign root_tag  = root_r[TAG_BITS-1:0];
  assign count     = count_r;

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for binary_min_heap_queue_core: a software heap predicts each result.
// Driver and monitor are clocked always blocks; depends on bmhq_pkg and the core.
`timescale 1ns / 1ps

module tb;

  localparam int CAP = bmhq_pkg::CAPACITY_DEF;
  localparam int CW  = $clog2(CAP + 1);

  typedef struct {
    logic              kind;
    logic signed [15:0] prio;
    logic [15:0]       tag;
  } cmd_item_t;

  typedef struct {
    logic signed [15:0] prio;
    logic [15:0]        tag;
    logic [CW-1:0]      count;
    logic               empty;
    bmhq_pkg::err_t     err;
  } heap_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_kind = 1'b0;
  logic signed [15:0] in_priority_req = '0;
  logic [15:0] in_payload_tag = '0;
  logic out_valid;
  logic signed [15:0] out_top_priority;
  logic [15:0] out_top_tag;
  logic [CW-1:0] out_entry_count;
  logic out_is_empty;
  logic [1:0] out_error_code;

  binary_min_heap_queue_core dut (
    .clk, .rst_n, .start, .busy, .in_kind, .in_priority_req, .in_payload_tag,
    .out_valid, .out_top_priority, .out_top_tag, .out_entry_count, .out_is_empty,
    .out_error_code
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cmd_item_t pending_cmds[$];
  heap_res_t expected_results[$];
  logic signed [15:0] heap_prio[CAP];
  logic [15:0] heap_tag[CAP];
  int heap_count = 0;
  int errors = 0;

  function automatic void swap_entries(int a, int b);
    logic signed [15:0] p;
    logic [15:0] t;
    p = heap_prio[a]; t = heap_tag[a];
    heap_prio[a] = heap_prio[b]; heap_tag[a] = heap_tag[b];
    heap_prio[b] = p; heap_tag[b] = t;
  endfunction

  function automatic heap_res_t apply_heap_cmd(cmd_item_t c);
    heap_res_t r;
    int pos, par, lf, pick;
    r.err = bmhq_pkg::ERR_OK;
    if (c.kind == 1'b0) begin
      if (heap_count >= CAP) begin
        r.err = bmhq_pkg::ERR_FULL;
      end else begin
        pos = heap_count;
        heap_prio[pos] = c.prio;
        heap_tag[pos] = c.tag;
        heap_count++;
        while (pos > 0) begin
          par = (pos - 1) / 2;
          if (!(heap_prio[pos] < heap_prio[par])) break;
          swap_entries(pos, par);
          pos = par;
        end
      end
    end else begin
      if (heap_count == 0) begin
        r.err = bmhq_pkg::ERR_EMPTY;
      end else begin
        heap_count--;
        heap_prio[0] = heap_prio[heap_count];
        heap_tag[0] = heap_tag[heap_count];
        pos = 0;
        forever begin
          lf = 2 * pos + 1;
          if (lf >= heap_count) break;
          pick = lf;
          if (lf + 1 < heap_count && heap_prio[lf + 1] < heap_prio[lf]) pick = lf + 1;
          if (heap_prio[pick] >= heap_prio[pos]) break;
          swap_entries(pick, pos);
          pos = pick;
        end
      end
    end
    r.prio = heap_count > 0 ? heap_prio[0] : '0;
    r.tag = heap_count > 0 ? heap_tag[0] : '0;
    r.count = heap_count[CW-1:0];
    r.empty = heap_count == 0;
    return r;
  endfunction

  function automatic void push_cmd(logic k, logic signed [15:0] p, logic [15:0] t);
    cmd_item_t c;
    c.kind = k; c.prio = p; c.tag = t;
    pending_cmds.push_back(c);
  endfunction

  // Driver: a gap is drawn after every accepted beat.
  int gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        expected_results.push_back(apply_heap_cmd(pending_cmds.pop_front()));
        gap = $urandom_range(3) == 0 ? 0 : $urandom_range(8);
      end
      if (start && busy) begin
        // Hold the beat until it is taken.
      end else if (gap > 0 || pending_cmds.size() == 0) begin
        start <= 1'b0;
        if (gap > 0 && !(start && !busy)) gap--;
      end else begin
        start <= 1'b1;
        in_kind <= pending_cmds[0].kind;
        in_priority_req <= pending_cmds[0].prio;
        in_payload_tag <= pending_cmds[0].tag;
      end
    end
  end

  // Monitor.
  always @(posedge clk) begin
    heap_res_t e;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected: prio %0d tag %0h", $realtime,
                 out_top_priority, out_top_tag);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_top_priority !== e.prio) begin
          $display("%0t: top_priority expected %0d actual %0d", $realtime, e.prio,
                   out_top_priority);
          errors++;
        end
        if (out_top_tag !== e.tag) begin
          $display("%0t: top_tag expected %0h actual %0h", $realtime, e.tag, out_top_tag);
          errors++;
        end
        if (out_entry_count !== e.count) begin
          $display("%0t: entry_count expected %0d actual %0d", $realtime, e.count,
                   out_entry_count);
          errors++;
        end
        if (out_is_empty !== e.empty) begin
          $display("%0t: is_empty expected %0b actual %0b", $realtime, e.empty, out_is_empty);
          errors++;
        end
        if (out_error_code !== e.err) begin
          $display("%0t: error_code expected %0d actual %0d", $realtime, e.err,
                   out_error_code);
          errors++;
        end
      end
    end
  end

  initial begin
    int fill, mode;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    // Directed: remove on empty, extremes, ties, fill to full, insert on full, drain.
    push_cmd(1'b1, 16'sh7fff, 16'hffff);
    push_cmd(1'b0, 16'sh7fff, 16'hffff);
    push_cmd(1'b0, -16'sd32768, 16'h0000);
    push_cmd(1'b0, 16'sd0, 16'h1234);
    push_cmd(1'b0, 16'sd0, 16'h5678);
    push_cmd(1'b0, -16'sd32768, 16'haaaa);
    for (int i = 0; i < 5; i++) push_cmd(1'b1, '0, '0);
    push_cmd(1'b1, '0, '0);
    for (int i = 0; i < CAP; i++) push_cmd(1'b0, 16'(CAP - i), 16'(i));
    push_cmd(1'b0, -16'sd5, 16'hbeef);
    for (int i = 0; i < CAP + 1; i++) push_cmd(1'b1, '0, '0);
    // Random: phases biased to fill, drain or churn so the heap runs the whole range.
    for (int ph = 0; ph < 20; ph++) begin
      mode = $urandom_range(2);
      fill = 40 + $urandom_range(30);
      for (int i = 0; i < fill; i++) begin
        logic k;
        k = mode == 0 ? ($urandom_range(9) < 2) : mode == 1 ? ($urandom_range(9) < 8)
                      : 1'($urandom_range(1));
        push_cmd(k, $urandom_range(3) == 0 ? 16'($urandom_range(7)) : 16'($urandom),
                 16'($urandom));
      end
    end
    wait (pending_cmds.size() == 0);
    wait (expected_results.size() == 0);
    repeat (30) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end
endmodule
